[src/stq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Shared sizes, codes and types for the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam int DEPTH      = 32;
   localparam int TIME_BITS  = 32;
   localparam int NSLOTS     = 32;
   localparam int SLOT_W     = 5;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int POP_W      = $clog2(NSLOTS);

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_UPDATE = 2'd1,
      OP_DELETE = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_FULL       = 3'd1,
      ST_QUEUED     = 3'd2,
      ST_NOT_QUEUED = 3'd3,
      ST_NONE       = 3'd4
   } status_type;

   typedef enum logic {
      KIND_STATUS = 1'b0,
      KIND_EXPIRY = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_INSERT,
      BK_TICK
   } back_state_type;

   // key is the expiry for add/update and the current time for a tick
   typedef struct packed {
      op_type                 op;
      logic [SLOT_W-1:0]      slot;
      logic [TIME_BITS-1:0]   key;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

endpackage

[src/stq_if.sv]
// ----------------------------------------------------------------------------
// Sorted timer queue channels
// Request and response channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface stq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [4:0]  slot;
   logic [31:0] expire_time;
   logic [31:0] now_time;

   modport source (output valid, op, slot, expire_time, now_time, input ready);
   modport sink   (input valid, op, slot, expire_time, now_time, output ready);
endinterface

interface stq_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [4:0]  slot_out;
   logic [2:0]  status;
   logic [31:0] expire_out;
   logic        last;

   modport source (output valid, kind, slot_out, status, expire_out, last, input ready);
   modport sink   (input valid, kind, slot_out, status, expire_out, last, output ready);
endinterface

[src/sorted_timer_queue.sv]
// ----------------------------------------------------------------------------
// Sorted timer queue
// Timer slots kept in expiry order; add, update, delete and expiry ticks.
// ----------------------------------------------------------------------------
//  channel   direction  transfer on        carries
//  req_ch    in         valid && ready     op, slot, expire_time, now_time
//  rsp_ch    out        valid && ready     kind, slot_out, status, expire_out, last
//
//  Add and delete finish in the idle state; update removes a queued slot there,
//  then inserts it in the insert state. A tick moves to the tick state, then
//  pops one expired slot per response, or sends ST_NONE if none has expired.
//  Rate is set by the back end's single sorted cell row; a two-entry
//  command queue lets requests transfer while responses are stalled.
//  Reset empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_timer_queue (
   input  logic      clock,
   input  logic      reset,
   stq_req_if.sink   req_ch,
   stq_rsp_if.source rsp_ch
);

   stq_pkg::cmd_head_type cmd_head;
   logic                  cmd_pop;

   stq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .cmd_pop  (cmd_pop),
      .cmd_head (cmd_head)
   );

   stq_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_head (cmd_head),
      .cmd_pop  (cmd_pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

[src/stq_front.sv]
// ----------------------------------------------------------------------------
// Sorted timer queue front end
// Accepts requests, forms commands and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module stq_front (
   input  logic                clock,
   input  logic                reset,
   stq_req_if.sink             req_ch,
   input  logic                cmd_pop,
   output stq_pkg::cmd_head_type cmd_head
);

   stq_pkg::cmd_type q_ff [2];
   stq_pkg::cmd_type new_cmd;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   logic       pop;

   assign req_ch.ready = (fill_ff != 2'd2);
   assign push = req_ch.valid && req_ch.ready;
   assign pop  = cmd_pop && (fill_ff != 2'd0);

   always_comb begin
      new_cmd.op   = stq_pkg::op_type'(req_ch.op);
      new_cmd.slot = req_ch.slot;
      if (req_ch.op == stq_pkg::OP_TICK) begin
         new_cmd.key = req_ch.now_time[stq_pkg::TIME_BITS-1:0];
      end else begin
         new_cmd.key = req_ch.expire_time[stq_pkg::TIME_BITS-1:0];
      end
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign cmd_head.valid = (fill_ff != 2'd0);
   assign cmd_head.cmd   = q_ff[rd_ptr_ff];

endmodule

[src/stq_back.sv]
// ----------------------------------------------------------------------------
// Sorted timer queue back end
// Row of sorted cells with insert, remove and head pop; drives responses.
// ----------------------------------------------------------------------------
module stq_back (
   input  logic                  clock,
   input  logic                  reset,
   input  stq_pkg::cmd_head_type cmd_head,
   output logic                  cmd_pop,
   stq_rsp_if.source             rsp_ch
);

   localparam int DEPTH = stq_pkg::DEPTH;
   localparam int TB    = stq_pkg::TIME_BITS;

   logic [stq_pkg::SLOT_W-1:0] slot_ff [DEPTH];
   logic [stq_pkg::SLOT_W-1:0] slot_in [DEPTH];
   logic [TB-1:0]              exp_ff  [DEPTH];
   logic [TB-1:0]              exp_in  [DEPTH];
   logic [stq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [stq_pkg::NSLOTS-1:0] queued_ff, queued_in;
   logic [stq_pkg::POP_W-1:0]  popped_ff, popped_in;
   stq_pkg::back_state_type    state_ff, state_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [4:0]  rsp_slot_ff, rsp_slot_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_expire_ff, rsp_expire_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [DEPTH-1:0] le;
   logic [DEPTH-1:0] after;
   logic             out_free;
   logic             do_ins, do_rem, do_pop;
   logic             head_due, next_due;
   stq_pkg::cmd_type cmd;

   assign cmd      = cmd_head.cmd;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // le is a prefix (list is sorted); after marks the matched cell onward
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         le[i] = (stq_pkg::CNT_W'(i) < count_ff) && (exp_ff[i] <= cmd.key);
      end
      after[0] = (count_ff != '0) && (slot_ff[0] == cmd.slot);
      for (int i = 1; i < DEPTH; i++) begin
         after[i] = after[i-1] ||
                    ((stq_pkg::CNT_W'(i) < count_ff) && (slot_ff[i] == cmd.slot));
      end
      head_due = le[0];
      next_due = le[1];
   end

   always_comb begin
      state_in      = state_ff;
      popped_in     = popped_ff;
      queued_in     = queued_ff;
      do_ins        = 1'b0;
      do_rem        = 1'b0;
      do_pop        = 1'b0;
      cmd_pop       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_expire_in = rsp_expire_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         stq_pkg::BK_IDLE: begin
            popped_in = '0;
            if (cmd_head.valid && out_free) begin
               rsp_kind_in   = stq_pkg::KIND_STATUS;
               rsp_slot_in   = cmd.slot;
               rsp_expire_in = '0;
               rsp_last_in   = 1'b1;
               case (cmd.op)
                  stq_pkg::OP_ADD: begin
                     rsp_valid_in = 1'b1;
                     cmd_pop      = 1'b1;
                     if (queued_ff[cmd.slot]) begin
                        rsp_status_in = stq_pkg::ST_QUEUED;
                     end else if (count_ff >= stq_pkg::CNT_W'(DEPTH)) begin
                        rsp_status_in = stq_pkg::ST_FULL;
                     end else begin
                        rsp_status_in        = stq_pkg::ST_OK;
                        do_ins               = 1'b1;
                        queued_in[cmd.slot]  = 1'b1;
                     end
                  end
                  stq_pkg::OP_UPDATE: begin
                     if (queued_ff[cmd.slot]) begin
                        do_rem   = 1'b1;
                        state_in = stq_pkg::BK_INSERT;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = stq_pkg::ST_NOT_QUEUED;
                        cmd_pop       = 1'b1;
                     end
                  end
                  stq_pkg::OP_DELETE: begin
                     rsp_valid_in = 1'b1;
                     cmd_pop      = 1'b1;
                     if (queued_ff[cmd.slot]) begin
                        do_rem              = 1'b1;
                        queued_in[cmd.slot] = 1'b0;
                        rsp_status_in       = stq_pkg::ST_OK;
                     end else begin
                        rsp_status_in = stq_pkg::ST_NOT_QUEUED;
                     end
                  end
                  stq_pkg::OP_TICK: begin
                     state_in = stq_pkg::BK_TICK;
                  end
                  default: begin
                     state_in = stq_pkg::BK_IDLE;
                  end
               endcase
            end
         end
         stq_pkg::BK_INSERT: begin
            if (out_free) begin
               do_ins        = 1'b1;
               cmd_pop       = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = stq_pkg::KIND_STATUS;
               rsp_slot_in   = cmd.slot;
               rsp_status_in = stq_pkg::ST_OK;
               rsp_expire_in = '0;
               rsp_last_in   = 1'b1;
               state_in      = stq_pkg::BK_IDLE;
            end
         end
         stq_pkg::BK_TICK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (head_due) begin
                  do_pop               = 1'b1;
                  queued_in[slot_ff[0]] = 1'b0;
                  popped_in            = popped_ff + 1'b1;
                  rsp_kind_in          = stq_pkg::KIND_EXPIRY;
                  rsp_slot_in          = slot_ff[0];
                  rsp_status_in        = stq_pkg::ST_OK;
                  rsp_expire_in        = 32'(exp_ff[0]);
                  rsp_last_in          = !next_due || (popped_ff == '1);
               end else begin
                  rsp_kind_in   = stq_pkg::KIND_STATUS;
                  rsp_slot_in   = '0;
                  rsp_status_in = stq_pkg::ST_NONE;
                  rsp_expire_in = '0;
                  rsp_last_in   = 1'b1;
               end
               if (rsp_last_in) begin
                  cmd_pop  = 1'b1;
                  state_in = stq_pkg::BK_IDLE;
               end
            end
         end
         default: begin
            state_in = stq_pkg::BK_IDLE;
         end
      endcase
   end

   // cell updates: insert shifts up past the insertion point, remove/pop shift down
   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + 1'b1;
      end else if (do_rem || do_pop) begin
         count_in = count_ff - 1'b1;
      end
      for (int i = 0; i < DEPTH; i++) begin
         slot_in[i] = slot_ff[i];
         exp_in[i]  = exp_ff[i];
         if (do_ins && !le[i]) begin
            if (i == 0 || le[(i == 0) ? 0 : i-1]) begin
               slot_in[i] = cmd.slot;
               exp_in[i]  = cmd.key;
            end else begin
               slot_in[i] = slot_ff[(i == 0) ? 0 : i-1];
               exp_in[i]  = exp_ff[(i == 0) ? 0 : i-1];
            end
         end else if ((do_rem && after[i]) || do_pop) begin
            if (i < DEPTH-1) begin
               slot_in[i] = slot_ff[(i < DEPTH-1) ? i+1 : i];
               exp_in[i]  = exp_ff[(i < DEPTH-1) ? i+1 : i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stq_pkg::BK_IDLE;
         count_ff     <= '0;
         queued_ff    <= '0;
         popped_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         queued_ff    <= queued_in;
         popped_ff    <= popped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
         exp_ff[i]  <= exp_in[i];
      end
      rsp_kind_ff   <= rsp_kind_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_expire_ff <= rsp_expire_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.kind       = rsp_kind_ff;
   assign rsp_ch.slot_out   = rsp_slot_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.expire_out = rsp_expire_ff;
   assign rsp_ch.last       = rsp_last_ff;

endmodule
